// ----- sv/cab_pkg.sv -----
// Shared types and constants for the clipped alpha blend compositor.
// Holds register codes, the pixel, item, result and configuration structs, and the blend finish.
// No dependencies.
`timescale 1ns / 1ps

package cab_pkg;

  localparam int DIM_W = 13;
  localparam int POS_W = 12;
  localparam int CH_W  = 8;
  localparam int IDX_W = 24;
  localparam int PROD_W = 2 * CH_W;
  localparam int MUL_W = 2 * DIM_W;
  localparam int REG_IDX_W = 3;

  localparam logic [CH_W-1:0]   CH_MAX    = 8'd255;
  localparam logic [PROD_W-1:0] ROUND_ADD = 16'h0080;

  localparam logic [DIM_W-1:0] RST_DEST_WIDTH  = 13'd1024;
  localparam logic [DIM_W-1:0] RST_DEST_HEIGHT = 13'd768;
  localparam logic [DIM_W-1:0] RST_TOP_WIDTH   = 13'd128;
  localparam logic [DIM_W-1:0] RST_TOP_HEIGHT  = 13'd128;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_DEST_WIDTH     = 3'd0,
    REG_DEST_HEIGHT    = 3'd1,
    REG_TOP_WIDTH      = 3'd2,
    REG_TOP_HEIGHT     = 3'd3,
    REG_PLACE_X        = 3'd4,
    REG_PLACE_Y        = 3'd5,
    REG_BLEND_MODE     = 3'd6,
    REG_DEST_HAD_ALPHA = 3'd7
  } cab_reg_t;

  typedef struct packed {
    logic [CH_W-1:0] src_red;
    logic [CH_W-1:0] src_green;
    logic [CH_W-1:0] src_blue;
    logic [CH_W-1:0] src_alpha;
    logic [CH_W-1:0] under_red;
    logic [CH_W-1:0] under_green;
    logic [CH_W-1:0] under_blue;
    logic [CH_W-1:0] under_alpha;
  } cab_pixel_t;

  typedef struct packed {
    logic [DIM_W-1:0] dx;
    logic [DIM_W-1:0] dy;
    cab_pixel_t       px;
  } cab_item_t;

  typedef struct packed {
    logic [IDX_W-1:0] dest_index;
    logic [CH_W-1:0]  red;
    logic [CH_W-1:0]  green;
    logic [CH_W-1:0]  blue;
    logic [CH_W-1:0]  alpha;
  } cab_result_t;

  typedef struct packed {
    logic [DIM_W-1:0] dest_width;
    logic [DIM_W-1:0] dest_height;
    logic [DIM_W-1:0] top_width;
    logic [DIM_W-1:0] top_height;
    logic [POS_W-1:0] place_x;
    logic [POS_W-1:0] place_y;
    logic             blend_mode;
    logic             dest_had_alpha;
  } cab_cfg_t;

  // t = pd + ps + 0x80, out = (t + (t >> 8)) >> 8; never exceeds 16 bits
  function automatic logic [CH_W-1:0] blend_finish(input logic [PROD_W-1:0] pd,
                                                  input logic [PROD_W-1:0] ps);
    logic [PROD_W-1:0] t;
    logic [PROD_W-1:0] u;
    t = pd + ps + ROUND_ADD;
    u = t + {{CH_W{1'b0}}, t[PROD_W-1:CH_W]};
    return u[PROD_W-1:CH_W];
  endfunction

endpackage

// ----- sv/cab_fifo.sv -----
// Small first-word-fall-through queue used between front, back and result port.
// Generic width and depth; no package dependency.
`timescale 1ns / 1ps

module cab_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  logic [WIDTH-1:0]           wdata,
  output logic                       full,
  input  logic                       pop,
  output logic [WIDTH-1:0]           rdata,
  output logic                       empty,
  output logic [$clog2(DEPTH+1)-1:0] level
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entry_r [DEPTH];
  logic [PW-1:0]    wptr_r, wptr_nxt;
  logic [PW-1:0]    rptr_r, rptr_nxt;
  logic [LW-1:0]    count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == LW'(DEPTH));
  assign empty   = (count_r == '0);
  assign level   = count_r;
  assign rdata   = entry_r[rptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wptr_nxt  = wptr_r;
    rptr_nxt  = rptr_r;
    count_nxt = count_r;
    if (do_push) begin
      wptr_nxt = (wptr_r == PW'(DEPTH - 1)) ? '0 : wptr_r + PW'(1);
    end
    if (do_pop) begin
      rptr_nxt = (rptr_r == PW'(DEPTH - 1)) ? '0 : rptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + LW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - LW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wptr_r] <= wdata;
    end
  end

endmodule

// ----- sv/cab_front.sv -----
// Front end: column and row tracking over the top image and clipping to the destination.
// Depends on cab_pkg.
`timescale 1ns / 1ps

module cab_front #(
  parameter int MAX_DIM = 4096
) (
  input  logic                clk,
  input  logic                rst_n,
  input  cab_pkg::cab_cfg_t   cfg,
  input  logic                accept,
  input  cab_pkg::cab_pixel_t px,
  output logic                q_push,
  output cab_pkg::cab_item_t  q_item
);

  import cab_pkg::*;

  localparam int CW = $clog2(MAX_DIM);
  localparam int SW = ($clog2(MAX_DIM + 1) > DIM_W) ? $clog2(MAX_DIM + 1) : DIM_W;
  localparam int AW = ((CW > POS_W) ? CW : POS_W) + 1;

  logic [CW-1:0] col_r, col_nxt;
  logic [CW-1:0] row_r, row_nxt;
  logic [SW-1:0] tw_eff, th_eff;
  logic [AW-1:0] dx_sum, dy_sum;
  logic          hit, col_wrap, row_wrap;

  function automatic logic [SW-1:0] eff_size(input logic [DIM_W-1:0] v);
    logic [SW-1:0] r;
    if (v == '0) begin
      r = SW'(1);
    end else if (SW'(v) > SW'(MAX_DIM)) begin
      r = SW'(MAX_DIM);
    end else begin
      r = SW'(v);
    end
    return r;
  endfunction

  always_comb begin
    tw_eff   = eff_size(cfg.top_width);
    th_eff   = eff_size(cfg.top_height);
    dx_sum   = AW'(cfg.place_x) + AW'(col_r);
    dy_sum   = AW'(cfg.place_y) + AW'(row_r);
    hit      = (dx_sum < AW'(cfg.dest_width)) && (dy_sum < AW'(cfg.dest_height));
    col_wrap = (SW'(col_r) + SW'(1)) >= tw_eff;
    row_wrap = (SW'(row_r) + SW'(1)) >= th_eff;
    col_nxt  = col_r;
    row_nxt  = row_r;
    if (accept) begin
      if (col_wrap) begin
        col_nxt = '0;
        row_nxt = row_wrap ? '0 : row_r + CW'(1);
      end else begin
        col_nxt = col_r + CW'(1);
      end
    end
  end

  assign q_push    = accept && hit;
  assign q_item.dx = dx_sum[DIM_W-1:0];
  assign q_item.dy = dy_sum[DIM_W-1:0];
  assign q_item.px = px;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

endmodule

// ----- sv/cab_back.sv -----
// Back end: two-stage blend and destination index pipeline, issued against result queue room.
// Depends on cab_pkg.
`timescale 1ns / 1ps

module cab_back #(
  parameter int OUT_DEPTH = 4
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  cab_pkg::cab_cfg_t                  cfg,
  input  logic                               item_valid,
  input  cab_pkg::cab_item_t                 item,
  output logic                               item_pop,
  input  logic [$clog2(OUT_DEPTH+1)-1:0]     out_level,
  output logic                               res_push,
  output cab_pkg::cab_result_t               res
);

  import cab_pkg::*;

  localparam int LW = $clog2(OUT_DEPTH + 1) + 1;

  logic              s1_v_r;
  cab_pixel_t        s1_px_r;
  logic [DIM_W-1:0]  s1_dx_r;
  logic [MUL_W-1:0]  s1_mul_r;
  logic [PROD_W-1:0] s1_pd_r [3];
  logic [PROD_W-1:0] s1_ps_r [3];
  logic              s2_v_r;
  cab_result_t       res_r, res_nxt;
  logic [LW-1:0]     used;
  logic [CH_W-1:0]   inv_a;

  assign used     = LW'(out_level) + LW'(s1_v_r) + LW'(s2_v_r);
  assign item_pop = item_valid && (used < LW'(OUT_DEPTH));
  assign inv_a    = CH_MAX - item.px.src_alpha;

  // stage 1: products and row offset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= item_pop;
    end
  end

  always_ff @(posedge clk) begin
    if (item_pop) begin
      s1_px_r    <= item.px;
      s1_dx_r    <= item.dx;
      s1_mul_r   <= item.dy * cfg.dest_width;
      s1_pd_r[0] <= item.px.under_red * inv_a;
      s1_pd_r[1] <= item.px.under_green * inv_a;
      s1_pd_r[2] <= item.px.under_blue * inv_a;
      s1_ps_r[0] <= item.px.src_red * item.px.src_alpha;
      s1_ps_r[1] <= item.px.src_green * item.px.src_alpha;
      s1_ps_r[2] <= item.px.src_blue * item.px.src_alpha;
    end
  end

  // stage 2: round, select and index
  always_comb begin
    res_nxt.dest_index = IDX_W'(s1_mul_r + MUL_W'(s1_dx_r));
    if (cfg.blend_mode) begin
      res_nxt.red   = blend_finish(s1_pd_r[0], s1_ps_r[0]);
      res_nxt.green = blend_finish(s1_pd_r[1], s1_ps_r[1]);
      res_nxt.blue  = blend_finish(s1_pd_r[2], s1_ps_r[2]);
      res_nxt.alpha = cfg.dest_had_alpha ? '0 : s1_px_r.under_alpha;
    end else begin
      res_nxt.red   = s1_px_r.src_red;
      res_nxt.green = s1_px_r.src_green;
      res_nxt.blue  = s1_px_r.src_blue;
      res_nxt.alpha = s1_px_r.src_alpha;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_v_r) begin
      res_r <= res_nxt;
    end
  end

  assign res_push = s2_v_r;
  assign res      = res_r;

endmodule

// ----- sv/clipped_alpha_blend_compositor.sv -----
// Top level of the clipped alpha blend compositor: configuration registers and queues.
// Depends on cab_pkg, cab_fifo, cab_front and cab_back.
`timescale 1ns / 1ps

// Takes one top pixel per cycle while in_full is low, with the destination pixel under it, in
// raster order over the top image, and gives one result per pixel that lands inside the
// destination. Sustained rate is one pixel per cycle while results are popped; a result
// reaches the output ports through the front queue, product stage, rounding stage and
// result queue write, in that order. The front clips and drops off-destination pixels at
// once, so they take an input beat but no back-end slot. Full rises when the four-entry
// front queue fills, which happens only while results are not popped. No clearing pass after
// reset. Write configuration only while the block is idle.

module clipped_alpha_blend_compositor #(
  parameter int MAX_DIM = 4096
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [cab_pkg::REG_IDX_W-1:0]   cfg_index,
  input  logic [cab_pkg::DIM_W-1:0]       cfg_data,
  input  logic                            in_push,
  output logic                            in_full,
  input  logic [cab_pkg::CH_W-1:0]        in_src_red,
  input  logic [cab_pkg::CH_W-1:0]        in_src_green,
  input  logic [cab_pkg::CH_W-1:0]        in_src_blue,
  input  logic [cab_pkg::CH_W-1:0]        in_src_alpha,
  input  logic [cab_pkg::CH_W-1:0]        in_under_red,
  input  logic [cab_pkg::CH_W-1:0]        in_under_green,
  input  logic [cab_pkg::CH_W-1:0]        in_under_blue,
  input  logic [cab_pkg::CH_W-1:0]        in_under_alpha,
  output logic                            out_empty,
  input  logic                            out_pop,
  output logic [cab_pkg::IDX_W-1:0]       out_dest_index,
  output logic [cab_pkg::CH_W-1:0]        out_red,
  output logic [cab_pkg::CH_W-1:0]        out_green,
  output logic [cab_pkg::CH_W-1:0]        out_blue,
  output logic [cab_pkg::CH_W-1:0]        out_alpha
);

  import cab_pkg::*;

  localparam int MID_DEPTH = 4;
  localparam int OUT_DEPTH = 4;
  localparam int OLW = $clog2(OUT_DEPTH + 1);

  cab_cfg_t    cfg_r, cfg_nxt;
  cab_pixel_t  in_px;
  cab_item_t   f_item, b_item;
  cab_result_t b_res, o_res;
  logic        accept, f_push, mid_full, mid_empty, b_pop, b_push;
  logic [OLW-1:0] out_level;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cab_reg_t'(cfg_index))
        REG_DEST_WIDTH:     cfg_nxt.dest_width     = cfg_data;
        REG_DEST_HEIGHT:    cfg_nxt.dest_height    = cfg_data;
        REG_TOP_WIDTH:      cfg_nxt.top_width      = cfg_data;
        REG_TOP_HEIGHT:     cfg_nxt.top_height     = cfg_data;
        REG_PLACE_X:        cfg_nxt.place_x        = cfg_data[POS_W-1:0];
        REG_PLACE_Y:        cfg_nxt.place_y        = cfg_data[POS_W-1:0];
        REG_BLEND_MODE:     cfg_nxt.blend_mode     = cfg_data[0];
        REG_DEST_HAD_ALPHA: cfg_nxt.dest_had_alpha = cfg_data[0];
        default:            cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.dest_width     <= RST_DEST_WIDTH;
      cfg_r.dest_height    <= RST_DEST_HEIGHT;
      cfg_r.top_width      <= RST_TOP_WIDTH;
      cfg_r.top_height     <= RST_TOP_HEIGHT;
      cfg_r.place_x        <= '0;
      cfg_r.place_y        <= '0;
      cfg_r.blend_mode     <= 1'b1;
      cfg_r.dest_had_alpha <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign in_px.src_red     = in_src_red;
  assign in_px.src_green   = in_src_green;
  assign in_px.src_blue    = in_src_blue;
  assign in_px.src_alpha   = in_src_alpha;
  assign in_px.under_red   = in_under_red;
  assign in_px.under_green = in_under_green;
  assign in_px.under_blue  = in_under_blue;
  assign in_px.under_alpha = in_under_alpha;

  assign in_full = mid_full;
  assign accept  = in_push && !mid_full;

  cab_front #(
    .MAX_DIM(MAX_DIM)
  ) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg_r),
    .accept (accept),
    .px     (in_px),
    .q_push (f_push),
    .q_item (f_item)
  );

  cab_fifo #(
    .WIDTH($bits(cab_item_t)),
    .DEPTH(MID_DEPTH)
  ) u_mid_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (f_push),
    .wdata (f_item),
    .full  (mid_full),
    .pop   (b_pop),
    .rdata (b_item),
    .empty (mid_empty),
    .level ()
  );

  cab_back #(
    .OUT_DEPTH(OUT_DEPTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .item_valid (!mid_empty),
    .item       (b_item),
    .item_pop   (b_pop),
    .out_level  (out_level),
    .res_push   (b_push),
    .res        (b_res)
  );

  cab_fifo #(
    .WIDTH($bits(cab_result_t)),
    .DEPTH(OUT_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (b_push),
    .wdata (b_res),
    .full  (),
    .pop   (out_pop),
    .rdata (o_res),
    .empty (out_empty),
    .level (out_level)
  );

  assign out_dest_index = o_res.dest_index;
  assign out_red        = o_res.red;
  assign out_green      = o_res.green;
  assign out_blue       = o_res.blue;
  assign out_alpha      = o_res.alpha;

endmodule
